// ===== rtl/core/gha_pkg.sv =====
// Shared constants, types and codes for the generational handle allocator.
`timescale 1ns / 1ps
package gha_pkg;

  localparam int SLOTS   = 1024;
  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int VER_W   = 16;
  localparam int ST_W    = 2;
  localparam int DATA_W  = 32;

  typedef enum logic {
    REQ_ALLOC   = 1'b0,
    REQ_RELEASE = 1'b1
  } req_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_VER,
    S_REL,
    S_FIN
  } state_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [VER_W-1:0] ver;
    status_t          st;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } stack_port_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VER_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } ver_port_t;

endpackage

// ===== rtl/core/gha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module gha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/gha_ctrl.sv =====
// Request sequencer: counters, memory read-modify-write and result formation.
`timescale 1ns / 1ps
module gha_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  gha_pkg::req_t            req_type,
  input  logic [gha_pkg::IDX_W-1:0] req_idx,
  input  logic [gha_pkg::VER_W-1:0] req_ver,
  output gha_pkg::stack_port_t     stack_port,
  input  logic [gha_pkg::IDX_W-1:0] stack_rdata,
  output gha_pkg::ver_port_t       ver_port,
  input  logic [gha_pkg::VER_W-1:0] ver_rdata,
  output logic                     res_valid,
  input  logic                     res_ready,
  output gha_pkg::result_t         res
);
  import gha_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic [CNT_W-1:0] used_cnt_r, used_cnt_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [VER_W-1:0] ver_r, ver_nxt;
  result_t          res_r, res_nxt;

  logic             accept;
  logic             have_free;
  logic             have_fresh;
  logic             rel_ok;
  logic             ver_match;
  logic [CNT_W-1:0] free_dec;

  assign req_ready  = (state_r == S_IDLE);
  assign accept     = req_valid && req_ready;
  assign have_free  = (free_cnt_r != '0);
  assign have_fresh = (used_cnt_r < CNT_W'(SLOTS));
  assign rel_ok     = ({{(CNT_W-IDX_W){1'b0}}, req_idx} < used_cnt_r) &&
                      (free_cnt_r < CNT_W'(SLOTS));
  assign ver_match  = (ver_rdata == ver_r);
  assign free_dec   = free_cnt_r - CNT_W'(1);
  assign res_valid  = (state_r == S_FIN);
  assign res        = res_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_type == REQ_ALLOC) begin
            state_nxt = have_free ? S_POP : S_FIN;
          end else begin
            state_nxt = rel_ok ? S_REL : S_FIN;
          end
        end
      end
      S_POP: state_nxt = S_VER;
      S_VER: state_nxt = S_FIN;
      S_REL: state_nxt = S_FIN;
      S_FIN: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    free_cnt_nxt = free_cnt_r;
    used_cnt_nxt = used_cnt_r;
    idx_nxt      = idx_r;
    ver_nxt      = ver_r;
    res_nxt      = res_r;
    stack_port   = '0;
    ver_port     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          idx_nxt = req_idx;
          ver_nxt = req_ver;
          if (req_type == REQ_ALLOC) begin
            if (have_free) begin
              stack_port.re    = 1'b1;
              stack_port.raddr = free_dec[IDX_W-1:0];
              free_cnt_nxt     = free_dec;
            end else if (have_fresh) begin
              ver_port.we    = 1'b1;
              ver_port.waddr = used_cnt_r[IDX_W-1:0];
              ver_port.wdata = '0;
              used_cnt_nxt   = used_cnt_r + CNT_W'(1);
              res_nxt        = '{idx: used_cnt_r[IDX_W-1:0], ver: '0, st: ST_OK};
            end else begin
              res_nxt = '{idx: '0, ver: '0, st: ST_FULL};
            end
          end else if (rel_ok) begin
            ver_port.re    = 1'b1;
            ver_port.raddr = req_idx;
          end else begin
            res_nxt = '{idx: '0, ver: '0, st: ST_STALE};
          end
        end
      end
      S_POP: begin
        ver_port.re    = 1'b1;
        ver_port.raddr = stack_rdata;
        idx_nxt        = stack_rdata;
      end
      S_VER: begin
        res_nxt = '{idx: idx_r, ver: ver_rdata, st: ST_OK};
      end
      S_REL: begin
        if (ver_match) begin
          ver_port.we      = 1'b1;
          ver_port.waddr   = idx_r;
          ver_port.wdata   = ver_rdata + VER_W'(1);
          stack_port.we    = 1'b1;
          stack_port.waddr = free_cnt_r[IDX_W-1:0];
          stack_port.wdata = idx_r;
          free_cnt_nxt     = free_cnt_r + CNT_W'(1);
          res_nxt          = '{idx: '0, ver: '0, st: ST_OK};
        end else begin
          res_nxt = '{idx: '0, ver: '0, st: ST_STALE};
        end
      end
      S_FIN: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      free_cnt_r <= '0;
      used_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      free_cnt_r <= free_cnt_nxt;
      used_cnt_r <= used_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    ver_r <= ver_nxt;
    res_r <= res_nxt;
  end

endmodule

// ===== rtl/core/generational_handle_allocator.sv =====
// Top level of the generational handle allocator: memories, sequencer, output register.
//
// Input channel (in_*): one request per transaction. in_tuser carries the
// request kind (0 allocate, 1 release); in_tdata carries the handle to release.
// Output channel (out_*): exactly one result transaction per request, in order,
// with the allocated handle in out_tdata and the status in out_tuser.
// Requests are handled one at a time. A fresh allocation, a full table or a
// rejected release goes straight to the final step; a release reads the
// version memory first, and an allocation that pops the free stack reads the
// stack, then the version memory. A new request is taken only once the
// sequencer is back in idle, after the previous result has entered the
// output register.
// The output register lets the next request be accepted while a result waits;
// a stalled receiver holds the sequencer in its final step until the register
// drains, and no result is dropped.
// Reset (rst_n low, synchronous) empties the free stack and the used count; the
// memories need no clearing since no entry is read before it is written.
`timescale 1ns / 1ps
module generational_handle_allocator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [gha_pkg::DATA_W-1:0]  in_tdata,   // [9:0] slot_index, [25:10] handle_version
  input  logic                        in_tuser,   // [0] req_type
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [gha_pkg::DATA_W-1:0]  out_tdata,  // [9:0] out_index, [25:10] out_version
  output logic [gha_pkg::ST_W-1:0]    out_tuser   // [1:0] status
);
  import gha_pkg::*;

  stack_port_t      stack_port;
  ver_port_t        ver_port;
  logic [IDX_W-1:0] stack_rdata;
  logic [VER_W-1:0] ver_rdata;
  logic             res_valid;
  logic             res_ready;
  result_t          res;
  req_t             req_type;

  logic                  out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]     out_data_r, out_data_nxt;
  logic [ST_W-1:0]       out_user_r, out_user_nxt;

  assign req_type = req_t'(in_tuser);

  gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_stack_ram (
    .clk   (clk),
    .we    (stack_port.we),
    .waddr (stack_port.waddr),
    .wdata (stack_port.wdata),
    .re    (stack_port.re),
    .raddr (stack_port.raddr),
    .rdata (stack_rdata)
  );

  gha_ram #(.WIDTH(VER_W), .DEPTH(SLOTS)) u_ver_ram (
    .clk   (clk),
    .we    (ver_port.we),
    .waddr (ver_port.waddr),
    .wdata (ver_port.wdata),
    .re    (ver_port.re),
    .raddr (ver_port.raddr),
    .rdata (ver_rdata)
  );

  gha_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (in_tvalid),
    .req_ready   (in_tready),
    .req_type    (req_type),
    .req_idx     (in_tdata[IDX_W-1:0]),
    .req_ver     (in_tdata[IDX_W+VER_W-1:IDX_W]),
    .stack_port  (stack_port),
    .stack_rdata (stack_rdata),
    .ver_port    (ver_port),
    .ver_rdata   (ver_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  assign res_ready = !out_valid_r || out_tready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {{(DATA_W-IDX_W-VER_W){1'b0}}, res.ver, res.idx};
      out_user_nxt  = res.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== dv/generational_handle_allocator_tb.sv =====
// Self-checking testbench for the generational handle allocator stream interface.
`timescale 1ns / 1ps
module generational_handle_allocator_tb;
  import gha_pkg::*;

  localparam int WATCHDOG  = 2000;
  localparam int RAND_REQS = 350;
  localparam int PAD_W     = DATA_W - IDX_W - VER_W;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic [VER_W-1:0] ver;
  } handle_t;

  class handle_scoreboard;
    logic [IDX_W-1:0] free_stk [SLOTS];
    logic [VER_W-1:0] slot_ver [SLOTS];
    int free_cnt;
    int used_cnt;
    result_t pending [$];
    int errors;
    int n_results;
    int n_ok;
    int n_full;
    int n_stale;

    function new();
      free_cnt  = 0;
      used_cnt  = 0;
      errors    = 0;
      n_results = 0;
      n_ok      = 0;
      n_full    = 0;
      n_stale   = 0;
    endfunction

    // Work out the answer to one accepted request and queue it.
    function result_t note_request(req_t kind, logic [IDX_W-1:0] idx,
                                   logic [VER_W-1:0] ver);
      result_t res;
      res.idx = '0;
      res.ver = '0;
      res.st  = ST_OK;
      if (kind == REQ_ALLOC) begin
        if (free_cnt != 0) begin
          free_cnt--;
          res.idx = free_stk[free_cnt];
          res.ver = slot_ver[res.idx];
        end else if (used_cnt < SLOTS) begin
          res.idx = IDX_W'(used_cnt);
          slot_ver[res.idx] = '0;
          used_cnt++;
        end else begin
          res.st = ST_FULL;
        end
      end else if (int'(idx) >= used_cnt || slot_ver[idx] != ver || free_cnt >= SLOTS) begin
        res.st = ST_STALE;
      end else begin
        free_stk[free_cnt] = idx;
        free_cnt++;
        slot_ver[idx] = slot_ver[idx] + 1'b1;
      end
      pending.insert(pending.size(), res);
      return res;
    endfunction

    function void check_result(result_t got);
      result_t exp;
      n_results++;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("result %0d unexpected: idx %0d ver %0d status %0d",
                   n_results, got.idx, got.ver, got.st);
        return;
      end
      exp = pending.pop_front();
      case (exp.st)
        ST_OK:   n_ok++;
        ST_FULL: n_full++;
        default: n_stale++;
      endcase
      if (got.idx !== exp.idx || got.ver !== exp.ver || got.st !== exp.st) begin
        errors++;
        if (errors <= 10)
          $display({"result %0d: expected idx %0d ver %0d status %0d,",
                    " got idx %0d ver %0d status %0d"},
                   n_results, exp.idx, exp.ver, exp.st, got.idx, got.ver, got.st);
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;
  logic              in_tuser;
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;
  logic [ST_W-1:0]   out_tuser;

  handle_scoreboard sb = new();
  handle_t live_pool [$];
  int in_idle_pct;
  int out_stall_pct;
  int n_req;
  int quiet_cycles;

  generational_handle_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= out_stall_pct);
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.idx = out_tdata[IDX_W-1:0];
        got.ver = out_tdata[IDX_W+VER_W-1:IDX_W];
        got.st  = status_t'(out_tuser);
        sb.check_result(got);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("generational_handle_allocator: mismatch");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  task automatic send_req(input req_t kind, input logic [IDX_W-1:0] idx,
                          input logic [VER_W-1:0] ver, output result_t exp);
    @(negedge clk);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {{PAD_W{1'b0}}, ver, idx};
    do @(posedge clk); while (!in_tready);
    exp = sb.note_request(kind, idx, ver);
    n_req++;
  endtask

  // Ignored fields of an allocate carry random bits.
  task automatic alloc_handle();
    result_t exp;
    handle_t h;
    send_req(REQ_ALLOC, IDX_W'($urandom_range(SLOTS - 1)), VER_W'($urandom), exp);
    if (exp.st == ST_OK) begin
      h.idx = exp.idx;
      h.ver = exp.ver;
      live_pool.insert(live_pool.size(), h);
    end
  endtask

  task automatic release_handle(input logic [IDX_W-1:0] idx, input logic [VER_W-1:0] ver);
    result_t exp;
    send_req(REQ_RELEASE, idx, ver, exp);
  endtask

  initial begin
    int pick;
    int k;
    handle_t h;
    logic [IDX_W-1:0] idx;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    n_req         = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty table, stale handles, double release, LIFO reuse
    release_handle(10'd0, 16'd0);
    alloc_handle();
    alloc_handle();
    alloc_handle();
    release_handle(10'd2, 16'hFFFF);
    release_handle(10'd1023, 16'd0);
    release_handle(10'd3, 16'd0);
    release_handle(10'd1, 16'd0);
    release_handle(10'd1, 16'd1);
    release_handle(10'd1, 16'd1);
    alloc_handle();
    alloc_handle();
    alloc_handle();
    release_handle(10'd0, 16'd0);
    release_handle(10'd2, 16'd0);
    release_handle(10'd0, 16'd0);
    alloc_handle();
    alloc_handle();
    release_handle(10'd1023, 16'hFFFF);

    // random: mostly valid handles, some double releases, stale versions and noise
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       begin in_idle_pct = 66; out_stall_pct = 0;  end
        2:       begin in_idle_pct = 0;  out_stall_pct = 66; end
        3:       begin in_idle_pct = 35; out_stall_pct = 35; end
        default: begin in_idle_pct = 0;  out_stall_pct = 0;  end
      endcase
      for (int i = 0; i < RAND_REQS / 5; i++) begin
        pick = $urandom_range(99);
        if (pick < 45 || (pick < 80 && live_pool.size() == 0)) begin
          alloc_handle();
        end else if (pick < 80) begin
          k = $urandom_range(live_pool.size() - 1);
          h = live_pool[k];
          live_pool.delete(k);
          release_handle(h.idx, h.ver);
        end else if (pick < 94 && sb.used_cnt > 0) begin
          idx = IDX_W'($urandom_range(sb.used_cnt - 1));
          if (pick < 88)
            release_handle(idx, sb.slot_ver[idx]);
          else
            release_handle(idx, sb.slot_ver[idx] ^ VER_W'($urandom_range(65535, 1)));
        end else begin
          release_handle(IDX_W'($urandom_range(SLOTS - 1)), VER_W'($urandom));
        end
      end
    end

    // fill the table, reject further allocations, then free and reuse the last slot
    in_idle_pct   = 35;
    out_stall_pct = 35;
    while (sb.used_cnt < SLOTS || sb.free_cnt != 0) alloc_handle();
    alloc_handle();
    alloc_handle();
    release_handle(10'd1023, sb.slot_ver[1023]);
    release_handle(10'd1023, sb.slot_ver[1023]);
    release_handle(10'd0, 16'hFFFF);
    while (sb.free_cnt != 0) alloc_handle();
    alloc_handle();

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    $display("%0d requests, %0d results: %0d ok, %0d table full, %0d stale or rejected",
             n_req, sb.n_results, sb.n_ok, sb.n_full, sb.n_stale);
    $display("exercised directed handle cases, four pacing mixes, a full table and reuse");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("generational_handle_allocator: match");
    end else begin
      $display("generational_handle_allocator: mismatch");
    end
    $finish;
  end

endmodule
